// File: rtl/mhkm_pkg.sv
`timescale 1ns / 1ps

package mhkm_pkg;

  localparam int MAX_WAYS = 16;
  localparam int IDX_W    = $clog2(MAX_WAYS);
  localparam int CNT_W    = 5;
  localparam int KEY_W    = 32;
  localparam int WAY_W    = 4;

  localparam logic [KEY_W-1:0] INT_MAX   = {1'b0, {(KEY_W-1){1'b1}}};
  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] WAYS_RST  = CNT_W'(2);
  localparam logic [CNT_W-1:0] WAYS_TOP  = CNT_W'(MAX_WAYS);

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [WAY_W-1:0] way;
  } entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BLD_RD,
    ST_BLD_LD,
    ST_SIFT,
    ST_EMIT_RD,
    ST_EMIT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic bld_rd;
    logic bld_ld;
    logic sift;
    logic rd_root;
    logic load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill;
    logic fill_last;
    logic sift_end;
    logic build_more;
    logic out_busy;
  } sts_t;

endpackage

// File: rtl/mhkm_in_if.sv
`timescale 1ns / 1ps

interface mhkm_in_if import mhkm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_value;
  logic [WAY_W-1:0] way_index;
  logic             exhausted;

  modport source(output valid, output key_value, output way_index, output exhausted,
                 input ready);
  modport sink(input valid, input key_value, input way_index, input exhausted,
               output ready);
endinterface

// File: rtl/mhkm_out_if.sv
`timescale 1ns / 1ps

interface mhkm_out_if import mhkm_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] min_value;
  logic [WAY_W-1:0] min_way;
  logic             all_done;

  modport source(output valid, output min_value, output min_way, output all_done,
                 input ready);
  modport sink(input valid, input min_value, input min_way, input all_done,
               output ready);
endinterface

// File: rtl/mhkm_ctrl.sv
`timescale 1ns / 1ps

module mhkm_ctrl import mhkm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  sts_t   sts,
  output cmd_t   cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          if (!sts.fill) begin
            state_next = ST_SIFT;
          end else if (sts.fill_last) begin
            state_next = ST_BLD_RD;
          end
        end
      end
      ST_BLD_RD: begin
        cmd.bld_rd = 1'b1;
        state_next = ST_BLD_LD;
      end
      ST_BLD_LD: begin
        cmd.bld_ld = 1'b1;
        state_next = ST_SIFT;
      end
      ST_SIFT: begin
        cmd.sift = 1'b1;
        if (sts.sift_end) begin
          state_next = sts.build_more ? ST_BLD_RD : ST_EMIT_RD;
        end
      end
      ST_EMIT_RD: begin
        cmd.rd_root = 1'b1;
        state_next  = ST_EMIT;
      end
      ST_EMIT: begin
        cmd.rd_root = 1'b1;
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/mhkm_dp.sv
`timescale 1ns / 1ps

module mhkm_dp import mhkm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  input  logic [KEY_W-1:0] key_value,
  input  logic [WAY_W-1:0] way_index,
  input  logic             exhausted,
  input  cmd_t             cmd,
  output sts_t             sts,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [KEY_W-1:0] min_value,
  output logic [WAY_W-1:0] min_way,
  output logic             all_done
);

  entry_t           mem [MAX_WAYS];
  entry_t           rd_a, rd_b;
  entry_t           hold;
  entry_t           new_ent;
  entry_t           child;
  entry_t           wr_data;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] addr_a, addr_b;

  logic [CNT_W-1:0] active_ways;
  logic [CNT_W-1:0] heap_n;
  logic [CNT_W-1:0] loaded_count;
  logic [CNT_W-1:0] done_count;
  logic             build_mode;
  logic [IDX_W-1:0] bld_idx;
  logic [IDX_W-1:0] cur_idx, cur_idx_next;
  logic             l_ok, r_ok;

  logic [IDX_W:0]   l_next;
  logic [IDX_W+1:0] r_next;
  logic [IDX_W:0]   l_cur;
  logic [IDX_W+1:0] r_cur;
  logic             take_l, take_r, stop;
  logic [KEY_W-1:0] best_key;
  logic [IDX_W-1:0] sel_idx;

  // Heap size in use; out-of-range settings are clamped.
  always_comb begin
    if (active_ways == '0) begin
      heap_n = CNT_W'(1);
    end else if (active_ways > WAYS_TOP) begin
      heap_n = WAYS_TOP;
    end else begin
      heap_n = active_ways;
    end
  end

  assign new_ent.key = exhausted ? INT_MAX : key_value;
  assign new_ent.way = way_index;

  // One level of sift-down: the held entry against the two children read last cycle.
  assign l_cur    = {cur_idx, 1'b1};
  assign r_cur    = {1'b0, cur_idx, 1'b0} + (IDX_W+2)'(2);
  assign take_l   = l_ok && ($signed(rd_a.key) < $signed(hold.key));
  assign best_key = take_l ? rd_a.key : hold.key;
  assign take_r   = r_ok && ($signed(rd_b.key) < $signed(best_key));
  assign stop     = !take_l && !take_r;
  assign child    = take_r ? rd_b : rd_a;
  assign sel_idx  = take_r ? r_cur[IDX_W-1:0] : l_cur[IDX_W-1:0];

  always_comb begin
    if (cmd.accept && !sts.fill) begin
      cur_idx_next = '0;
    end else if (cmd.bld_ld) begin
      cur_idx_next = bld_idx;
    end else if (cmd.sift && !stop) begin
      cur_idx_next = sel_idx;
    end else begin
      cur_idx_next = cur_idx;
    end
  end

  assign l_next = {cur_idx_next, 1'b1};
  assign r_next = {1'b0, cur_idx_next, 1'b0} + (IDX_W+2)'(2);

  always_comb begin
    if (cmd.bld_rd) begin
      addr_a = bld_idx;
    end else if (cmd.rd_root) begin
      addr_a = '0;
    end else begin
      addr_a = l_next[IDX_W-1:0];
    end
    addr_b = r_next[IDX_W-1:0];
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = cur_idx;
    wr_data = stop ? hold : child;
    if (cmd.accept && sts.fill) begin
      wr_en   = 1'b1;
      wr_addr = loaded_count[IDX_W-1:0];
      wr_data = new_ent;
    end else if (cmd.sift) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_a <= mem[addr_a];
    rd_b <= mem[addr_b];
  end

  always_ff @(posedge clk) begin
    cur_idx <= cur_idx_next;
    l_ok    <= l_next < heap_n;
    r_ok    <= r_next < {1'b0, heap_n};
    if (cmd.accept && !sts.fill) begin
      hold <= new_ent;
    end else if (cmd.bld_ld) begin
      hold <= rd_a;
    end
    if (cmd.accept && sts.fill && sts.fill_last) begin
      bld_idx <= IDX_W'((heap_n - CNT_W'(1)) >> 1);
    end else if (cmd.sift && stop && sts.build_more) begin
      bld_idx <= bld_idx - IDX_W'(1);
    end
    if (cmd.load_out) begin
      min_value <= rd_a.key;
      min_way   <= rd_a.way;
      all_done  <= done_count >= heap_n;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_ways  <= WAYS_RST;
      loaded_count <= '0;
      done_count   <= '0;
      build_mode   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        active_ways <= cfg_wr_data;
      end
      if (cmd.accept) begin
        build_mode <= sts.fill && sts.fill_last;
        if (sts.fill) begin
          loaded_count <= loaded_count + CNT_W'(1);
        end
        if (exhausted && (done_count != CNT_MAX)) begin
          done_count <= done_count + CNT_W'(1);
        end
      end
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign sts.fill       = loaded_count < heap_n;
  assign sts.fill_last  = ({1'b0, loaded_count} + (CNT_W+1)'(1)) >= {1'b0, heap_n};
  assign sts.sift_end   = stop;
  assign sts.build_more = build_mode && (bld_idx != '0);
  assign sts.out_busy   = out_valid && !out_ready;

endmodule

// File: rtl/min_heap_kway_merge.sv
`timescale 1ns / 1ps

// Min-heap selector for a k-way merge of sorted runs.
// The in_ch channel takes one item per element: key_value, the way it comes
// from, and exhausted, which replaces the key by the largest positive value.
// The out_ch channel gives the heap root (min_value, min_way) and all_done,
// which is set once the exhausted count reaches the heap size in use.
// active_ways is written through cfg_wr_en / cfg_wr_data; the user must write it
// only while the block is idle, as the block itself does not enforce this. Of
// the items that fill the heap (as many as the heap size in use), all but the
// last give no result. The last completes the fill, builds the heap bottom-up
// (one sub-heap at a time: its root is read and loaded as the held entry, then
// sifted down) and then gives the root. Every later item replaces the root and
// sifts down, one heap level per cycle through a two-read-port entry memory;
// the root is then read and loaded into the output register, and the next item
// is accepted in the cycle after the result is loaded.
// The output register holds its result while the receiver stalls; a new item
// may be accepted meanwhile, and its result waits until the register is free.
// Reset (rst, synchronous) empties the heap, clears the counts and sets
// active_ways to two. Heap entries themselves are not cleared.
module min_heap_kway_merge import mhkm_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CNT_W-1:0] cfg_wr_data,
  mhkm_in_if.sink          in_ch,
  mhkm_out_if.source       out_ch
);

  cmd_t cmd;
  sts_t sts;

  // Sequencing of fill, build, sift and emit steps.
  mhkm_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Entry memory, held entry, counters and the output register.
  mhkm_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .key_value   (in_ch.key_value),
    .way_index   (in_ch.way_index),
    .exhausted   (in_ch.exhausted),
    .cmd         (cmd),
    .sts         (sts),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .min_value   (out_ch.min_value),
    .min_way     (out_ch.min_way),
    .all_done    (out_ch.all_done)
  );

endmodule
